// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL of the transcoder.
// Each macro expects clk and rst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/core/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Error codes, codepoint limits, surrogate bases and sequence lengths of the UTF-8 to UTF-16LE transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  // Error codes carried by each result beat
  typedef logic [2:0] err_t;
  localparam err_t ERR_OK           = 3'd0;
  localparam err_t ERR_BAD_LEAD     = 3'd1;
  localparam err_t ERR_TRUNCATED    = 3'd2;
  localparam err_t ERR_MISSING_CONT = 3'd3;
  localparam err_t ERR_OVERLONG     = 3'd4;
  localparam err_t ERR_SURROGATE    = 3'd5;
  localparam err_t ERR_ABOVE_MAX    = 3'd6;

  typedef logic [20:0] cp_t;
  typedef logic [15:0] unit_t;

  // Codepoint limits
  localparam cp_t CP_MAX       = 21'h10FFFF;
  localparam cp_t CP_SUPP_BASE = 21'h010000;
  localparam cp_t CP_SUR_LO    = 21'h00D800;
  localparam cp_t CP_SUR_HI    = 21'h00DFFF;
  localparam cp_t CP_MIN_LEN2  = 21'h000080;
  localparam cp_t CP_MIN_LEN3  = 21'h000800;
  localparam cp_t CP_MIN_LEN4  = 21'h010000;

  // Surrogate bases
  localparam unit_t HI_SUR_BASE = 16'hD800;
  localparam unit_t LO_SUR_BASE = 16'hDC00;

  // Sequence lengths
  localparam logic [2:0] LEN_IDLE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

endpackage

`default_nettype wire

// File: rtl/core/utf8_to_utf16le_converter.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16le_converter
// UTF-8 byte stream in, UTF-16 code units with error reporting out.
// ----------------------------------------------------------------------------
// One input byte is taken every clock while in_stall is low. The decode of a
// byte is a single combinational pass from the sequence state into a result
// register. A byte completing a supplementary codepoint yields a surrogate
// pair: the high unit is shown first and the low unit waits in a second slot,
// the input being held off while it waits. Results appear the cycle after
// their byte is taken. After an error the rest of the string is dropped up to
// and including the byte flagged end_of_string.
`default_nettype none

module utf8_to_utf16le_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_string,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_code_unit,
  output logic [2:0]       out_error_code,
  output logic             out_string_end,
  output logic             out_last_of_run
);

  `include "assert_macros.svh"

  // Sequence state
  logic [2:0]        seq_len_r, seq_len_nxt;
  logic [2:0]        seen_r, seen_nxt;
  u8u16_pkg::cp_t    accum_r, accum_nxt;
  logic              bad_cont_r, bad_cont_nxt;
  logic              drain_r, drain_nxt;

  // Output slots: the shown beat and a waiting low surrogate
  logic              out_valid_r;
  logic [15:0]       out_unit_r;
  u8u16_pkg::err_t   out_err_r;
  logic              out_end_r;
  logic              out_last_r;
  logic              pend2_r;
  logic [15:0]       sec_unit_r;
  logic              sec_end_r;

  // Decode signals
  logic              in_accept;
  logic              do_emit;
  logic              do_err;
  u8u16_pkg::err_t   err_sel;
  u8u16_pkg::cp_t    emit_cp;
  u8u16_pkg::cp_t    acc_shift;
  logic [2:0]        seen_inc;
  logic              bad_cont_now;
  u8u16_pkg::cp_t    min_cp;
  logic              is_pair;
  logic [19:0]       pair_off;
  logic [15:0]       res0_unit;
  logic [15:0]       res1_unit;

  // Hold the input while the shown beat is stuck or a low surrogate waits
  assign in_stall  = (out_valid_r && out_stall) || pend2_r;
  assign in_accept = in_valid && !in_stall;

  // Per-byte decode
  always_comb begin
    seq_len_nxt  = seq_len_r;
    seen_nxt     = seen_r;
    accum_nxt    = accum_r;
    bad_cont_nxt = bad_cont_r;
    drain_nxt    = drain_r;
    do_emit      = 1'b0;
    do_err       = 1'b0;
    err_sel      = u8u16_pkg::ERR_OK;
    emit_cp      = '0;
    acc_shift    = {accum_r[14:0], in_data_byte[5:0]};
    seen_inc     = seen_r + 3'd1;
    bad_cont_now = bad_cont_r || (in_data_byte[7:6] != 2'b10);

    unique case (seq_len_r)
      u8u16_pkg::LEN_2: min_cp = u8u16_pkg::CP_MIN_LEN2;
      u8u16_pkg::LEN_3: min_cp = u8u16_pkg::CP_MIN_LEN3;
      u8u16_pkg::LEN_4: min_cp = u8u16_pkg::CP_MIN_LEN4;
      default:          min_cp = '0;
    endcase

    if (drain_r) begin
      // dropping bytes until the end of the string
      if (in_end_of_string) begin
        drain_nxt = 1'b0;
      end
    end else if (seq_len_r == u8u16_pkg::LEN_IDLE) begin
      // leading byte
      priority if (!in_data_byte[7]) begin
        do_emit = 1'b1;
        emit_cp = {13'd0, in_data_byte};
      end else if (in_data_byte[7:5] == 3'b110) begin
        seq_len_nxt = u8u16_pkg::LEN_2;
        accum_nxt   = {16'd0, in_data_byte[4:0]};
      end else if (in_data_byte[7:4] == 4'b1110) begin
        seq_len_nxt = u8u16_pkg::LEN_3;
        accum_nxt   = {17'd0, in_data_byte[3:0]};
      end else if (in_data_byte[7:3] == 5'b11110) begin
        seq_len_nxt = u8u16_pkg::LEN_4;
        accum_nxt   = {18'd0, in_data_byte[2:0]};
      end else begin
        do_err  = 1'b1;
        err_sel = u8u16_pkg::ERR_BAD_LEAD;
      end
      if (!do_err && in_data_byte[7]) begin
        seen_nxt     = 3'd1;
        bad_cont_nxt = 1'b0;
        if (in_end_of_string) begin
          do_err  = 1'b1;
          err_sel = u8u16_pkg::ERR_TRUNCATED;
        end
      end
    end else begin
      // continuation byte
      bad_cont_nxt = bad_cont_now;
      accum_nxt    = acc_shift;
      seen_nxt     = seen_inc;
      if (seen_inc >= seq_len_r) begin
        priority if (bad_cont_now) begin
          do_err  = 1'b1;
          err_sel = u8u16_pkg::ERR_MISSING_CONT;
        end else if (acc_shift < min_cp) begin
          do_err  = 1'b1;
          err_sel = u8u16_pkg::ERR_OVERLONG;
        end else if (acc_shift >= u8u16_pkg::CP_SUR_LO &&
                     acc_shift <= u8u16_pkg::CP_SUR_HI) begin
          do_err  = 1'b1;
          err_sel = u8u16_pkg::ERR_SURROGATE;
        end else if (acc_shift > u8u16_pkg::CP_MAX) begin
          do_err  = 1'b1;
          err_sel = u8u16_pkg::ERR_ABOVE_MAX;
        end else begin
          do_emit = 1'b1;
          emit_cp = acc_shift;
        end
      end else if (in_end_of_string) begin
        do_err  = 1'b1;
        err_sel = u8u16_pkg::ERR_TRUNCATED;
      end
    end

    // a finished or failed sequence leaves the state idle
    if (do_err || do_emit) begin
      seq_len_nxt  = u8u16_pkg::LEN_IDLE;
      seen_nxt     = '0;
      accum_nxt    = '0;
      bad_cont_nxt = 1'b0;
    end
    if (do_err) begin
      drain_nxt = !in_end_of_string;
    end
  end

  // Code unit forming
  assign is_pair   = do_emit && (emit_cp >= u8u16_pkg::CP_SUPP_BASE);
  assign pair_off  = 20'(emit_cp - u8u16_pkg::CP_SUPP_BASE);
  assign res0_unit = !do_emit ? 16'd0 :
                     is_pair  ? (u8u16_pkg::HI_SUR_BASE | {6'd0, pair_off[19:10]}) :
                                emit_cp[15:0];
  assign res1_unit = u8u16_pkg::LO_SUR_BASE | {6'd0, pair_off[9:0]};

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r   <= u8u16_pkg::LEN_IDLE;
      seen_r      <= '0;
      accum_r     <= '0;
      bad_cont_r  <= 1'b0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
      pend2_r     <= 1'b0;
    end else begin
      // retire the shown beat, bring up a waiting low surrogate
      if (out_valid_r && !out_stall) begin
        out_valid_r <= pend2_r;
        pend2_r     <= 1'b0;
      end
      if (in_accept) begin
        seq_len_r  <= seq_len_nxt;
        seen_r     <= seen_nxt;
        accum_r    <= accum_nxt;
        bad_cont_r <= bad_cont_nxt;
        drain_r    <= drain_nxt;
        if (do_emit || do_err) begin
          out_valid_r <= 1'b1;
        end
        if (is_pair) begin
          pend2_r <= 1'b1;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_valid_r && !out_stall && pend2_r) begin
      out_unit_r <= sec_unit_r;
      out_err_r  <= u8u16_pkg::ERR_OK;
      out_end_r  <= sec_end_r;
      out_last_r <= 1'b1;
    end
    if (in_accept && (do_emit || do_err)) begin
      out_unit_r <= res0_unit;
      out_err_r  <= err_sel;
      out_end_r  <= in_end_of_string;
      out_last_r <= !is_pair;
      sec_unit_r <= res1_unit;
      sec_end_r  <= in_end_of_string;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_unit   = out_unit_r;
  assign out_error_code  = out_err_r;
  assign out_string_end  = out_end_r;
  assign out_last_of_run = out_last_r;

  // Checks
  `ASSERT_IMP(a_pend_shown, pend2_r, out_valid_r && !out_last_r &&
              (out_err_r == u8u16_pkg::ERR_OK))
  `ASSERT_IMP(a_drain_idle, drain_r, seq_len_r == u8u16_pkg::LEN_IDLE)
  `ASSERT_IMP(a_err_zero, out_valid_r && (out_err_r != u8u16_pkg::ERR_OK),
              out_unit_r == 16'd0)
  `ASSERT_NEXT(a_low_follows, pend2_r && !out_stall, out_valid_r && out_last_r)

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for utf8_to_utf16le_converter: UTF-8 strings are fed a
// byte per beat, each taken byte is decoded by a local model into expected
// UTF-16 units and error beats, and every result beat is checked in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_BYTES = 1450;
  localparam int QUIET_BYTES  = 200;
  localparam int HOLD_CYCLES  = 60;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } utf8_beat_t;

  typedef struct packed {
    u8u16_pkg::unit_t code_unit;
    u8u16_pkg::err_t  error_code;
    logic             string_end;
    logic             last_of_run;
  } unit_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_string = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_code_unit;
  logic [2:0]  out_error_code;
  logic        out_string_end;
  logic        out_last_of_run;

  utf8_beat_t  utf8_bytes[$];
  unit_beat_t  expected_units[$];
  unit_beat_t  got_unit;
  unit_beat_t  want_unit;

  int mismatches = 0;
  int bytes_taken = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  logic recv_burst;
  logic hold_off = 1'b0;

  // Decoder state of the local model
  logic [2:0]       seq_len = u8u16_pkg::LEN_IDLE;
  logic [2:0]       seen = 3'd0;
  u8u16_pkg::cp_t   accum = '0;
  logic             bad_cont = 1'b0;
  logic             draining = 1'b0;

  utf8_to_utf16le_converter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_unit    (out_code_unit),
    .out_error_code   (out_error_code),
    .out_string_end   (out_string_end),
    .out_last_of_run  (out_last_of_run)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0d] MISMATCH %s", cycle_count, msg);
  endtask

  // ---------------------------------------------------------------- model
  task automatic clear_seq();
    seq_len  = u8u16_pkg::LEN_IDLE;
    seen     = 3'd0;
    accum    = '0;
    bad_cont = 1'b0;
  endtask

  // append one expected result beat
  task automatic add_expected(input u8u16_pkg::unit_t cu, input u8u16_pkg::err_t err,
                              input logic eos, input logic last);
    unit_beat_t beat;
    beat.code_unit   = cu;
    beat.error_code  = err;
    beat.string_end  = eos;
    beat.last_of_run = last;
    expected_units.insert(expected_units.size(), beat);
  endtask

  task automatic push_error(input u8u16_pkg::err_t err, input logic eos);
    clear_seq();
    draining = !eos;
    add_expected(16'h0000, err, eos, 1'b1);
  endtask

  task automatic push_codepoint(input u8u16_pkg::cp_t cp, input logic eos);
    logic [19:0] off;
    clear_seq();
    if (cp < u8u16_pkg::CP_SUPP_BASE) begin
      add_expected(cp[15:0], u8u16_pkg::ERR_OK, eos, 1'b1);
    end else begin
      // supplementary plane: surrogate pair, high half first
      off = 20'(cp - u8u16_pkg::CP_SUPP_BASE);
      add_expected(u8u16_pkg::HI_SUR_BASE + u8u16_pkg::unit_t'(off[19:10]),
                   u8u16_pkg::ERR_OK, eos, 1'b0);
      add_expected(u8u16_pkg::LO_SUR_BASE + u8u16_pkg::unit_t'(off[9:0]),
                   u8u16_pkg::ERR_OK, eos, 1'b1);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    u8u16_pkg::cp_t min_cp;
    // after an error everything up to the end-flagged byte is dropped
    if (draining) begin
      if (eos) begin
        draining = 1'b0;
        clear_seq();
      end
      return;
    end

    // leading byte
    if (seq_len == u8u16_pkg::LEN_IDLE) begin
      if (b < 8'h80) begin
        push_codepoint(u8u16_pkg::cp_t'(b), eos);
        return;
      end
      if (b[7:5] == 3'b110) begin
        seq_len = u8u16_pkg::LEN_2;
        accum = u8u16_pkg::cp_t'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        seq_len = u8u16_pkg::LEN_3;
        accum = u8u16_pkg::cp_t'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        seq_len = u8u16_pkg::LEN_4;
        accum = u8u16_pkg::cp_t'(b[2:0]);
      end else begin
        push_error(u8u16_pkg::ERR_BAD_LEAD, eos);
        return;
      end
      seen = 3'd1;
      bad_cont = 1'b0;
      if (eos) push_error(u8u16_pkg::ERR_TRUNCATED, eos);
      return;
    end

    // continuation byte; a bad one is only reported at full length
    if (b[7:6] != 2'b10) bad_cont = 1'b1;
    accum = {accum[14:0], b[5:0]};
    seen = seen + 3'd1;
    if (seen >= seq_len) begin
      case (seq_len)
        u8u16_pkg::LEN_2: min_cp = u8u16_pkg::CP_MIN_LEN2;
        u8u16_pkg::LEN_3: min_cp = u8u16_pkg::CP_MIN_LEN3;
        default:          min_cp = u8u16_pkg::CP_MIN_LEN4;
      endcase
      if (bad_cont) begin
        push_error(u8u16_pkg::ERR_MISSING_CONT, eos);
      end else if (accum < min_cp) begin
        push_error(u8u16_pkg::ERR_OVERLONG, eos);
      end else if (accum >= u8u16_pkg::CP_SUR_LO && accum <= u8u16_pkg::CP_SUR_HI) begin
        push_error(u8u16_pkg::ERR_SURROGATE, eos);
      end else if (accum > u8u16_pkg::CP_MAX) begin
        push_error(u8u16_pkg::ERR_ABOVE_MAX, eos);
      end else begin
        push_codepoint(accum, eos);
      end
    end else if (eos) begin
      push_error(u8u16_pkg::ERR_TRUNCATED, eos);
    end
  endtask

  // ------------------------------------------------------------- stimulus
  task automatic push_byte(input logic [7:0] b);
    utf8_beat_t ub;
    ub.data_byte     = b;
    ub.end_of_string = 1'b0;
    utf8_bytes.insert(utf8_bytes.size(), ub);
  endtask

  task automatic end_string();
    utf8_bytes[utf8_bytes.size() - 1].end_of_string = 1'b1;
  endtask

  // Encode cp in len bytes (forms may be overlong or out of range), optionally
  // overwrite byte bad_at, and queue only the first keep bytes
  task automatic encode_char(input u8u16_pkg::cp_t cp, input int len, input int keep,
                             input int bad_at, input logic [7:0] bad_byte);
    logic [7:0] seq [4];
    int i;
    seq[0] = 8'h00;
    seq[1] = {2'b10, cp[5:0]};
    seq[2] = {2'b10, cp[5:0]};
    seq[3] = {2'b10, cp[5:0]};
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: seq[0] = {3'b110, cp[10:6]};
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
      end
    endcase
    if (bad_at > 0) seq[bad_at] = bad_byte;
    for (i = 0; i < keep; i++) push_byte(seq[i]);
  endtask

  function automatic u8u16_pkg::cp_t valid_cp(input int len);
    case (len)
      1:       return u8u16_pkg::cp_t'($urandom_range(0, 32'h7F));
      2:       return u8u16_pkg::cp_t'($urandom_range(32'h80, 32'h7FF));
      3:       return u8u16_pkg::cp_t'($urandom_range(32'h800, 32'hFFFF));
      default: return u8u16_pkg::cp_t'($urandom_range(32'h10000, 32'h10FFFF));
    endcase
  endfunction

  function automatic logic [7:0] non_cont_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b[7:6] == 2'b10) b[6] = 1'b1;
    return b;
  endfunction

  initial begin
    int nchar;
    int c;
    int kind;
    int len;
    logic cut;
    u8u16_pkg::cp_t cp;

    // directed: the range ends 0, 7F, 80, FFFF and 10FFFF, then every error kind
    encode_char(21'h0, 1, 1, 0, 8'h00);
    end_string();
    encode_char(21'h7F, 1, 1, 0, 8'h00);
    encode_char(21'h80, 2, 2, 0, 8'h00);
    encode_char(21'hFFFF, 3, 3, 0, 8'h00);
    encode_char(u8u16_pkg::CP_MAX, 4, 4, 0, 8'h00);
    end_string();
    push_byte(8'h80);
    end_string();
    encode_char(21'h0, 2, 2, 0, 8'h00);
    end_string();
    encode_char(u8u16_pkg::CP_SUR_LO, 3, 3, 0, 8'h00);
    end_string();
    encode_char(21'h110000, 4, 4, 0, 8'h00);
    end_string();
    push_byte(8'hF8);
    push_byte(8'h41);
    end_string();
    encode_char(21'h2082, 3, 3, 1, 8'h41);
    end_string();
    encode_char(21'h2082, 3, 2, 1, 8'h41);
    end_string();
    push_byte(8'hF0);
    end_string();

    // random strings, mostly well formed with the odd fault
    while (utf8_bytes.size() < RANDOM_BYTES + 30) begin
      nchar = $urandom_range(1, 8);
      cut = 1'b0;
      for (c = 0; c < nchar && !cut; c++) begin
        kind = $urandom_range(0, 99);
        len = $urandom_range(2, 4);
        if (kind < 78) begin
          len = $urandom_range(1, 4);
          encode_char(valid_cp(len), len, len, 0, 8'h00);
        end else if (kind < 82) begin
          // overlong
          cp = valid_cp(len - 1);
          encode_char(cp, len, len, 0, 8'h00);
        end else if (kind < 85) begin
          encode_char(u8u16_pkg::cp_t'($urandom_range(32'hD800, 32'hDFFF)),
                      3, 3, 0, 8'h00);
        end else if (kind < 88) begin
          encode_char(u8u16_pkg::cp_t'($urandom_range(32'h110000, 32'h1FFFFF)),
                      4, 4, 0, 8'h00);
        end else if (kind < 91) begin
          push_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                         : 8'($urandom_range(8'hF8, 8'hFF)));
        end else if (kind < 94) begin
          push_byte(8'($urandom_range(0, 255)));
        end else if (kind < 97) begin
          encode_char(valid_cp(len), len, len, $urandom_range(1, len - 1), non_cont_byte());
        end else begin
          // string cut short inside a sequence
          encode_char(valid_cp(len), len, $urandom_range(1, len - 1), 0, 8'h00);
          cut = 1'b1;
        end
      end
      end_string();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all bytes sent, all units seen, then a short settle
    while (utf8_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_units.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ------------------------------------------------------------ driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'h00;
      in_end_of_string <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_data_byte, in_end_of_string);
        bytes_taken++;
      end
      // offer a new beat once the current one has gone
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (utf8_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else if (utf8_bytes.size() > QUIET_BYTES && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data_byte <= utf8_bytes[0].data_byte;
          in_end_of_string <= utf8_bytes[0].end_of_string;
          void'(utf8_bytes.pop_front());
        end
      end
    end
  end

  // ------------------------------------------------------------ monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_unit = {out_code_unit, out_error_code, out_string_end, out_last_of_run};
        if (expected_units.size() == 0) begin
          report_mismatch($sformatf("unexpected beat unit %h err %0d end %b last %b",
                                    got_unit.code_unit, got_unit.error_code,
                                    got_unit.string_end, got_unit.last_of_run));
        end else begin
          want_unit = expected_units.pop_front();
          if (got_unit !== want_unit)
            report_mismatch($sformatf(
              "unit %h/%h err %0d/%0d end %b/%b last %b/%b (got/want)",
              got_unit.code_unit, want_unit.code_unit,
              got_unit.error_code, want_unit.error_code,
              got_unit.string_end, want_unit.string_end,
              got_unit.last_of_run, want_unit.last_of_run));
        end
      end
      // stall bursts, none in the closing stretch
      if (recv_gap > 0) begin
        recv_gap--;
        recv_burst = 1'b1;
      end else if (utf8_bytes.size() > QUIET_BYTES && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 4);
        recv_burst = 1'b1;
      end else begin
        recv_burst = 1'b0;
      end
      out_stall <= hold_off || recv_burst;
    end
  end

  // Long receiver hold-off so the block backs up onto its input
  initial begin
    wait (bytes_taken >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
